FILE: rtl/hpack_huffman_string_packer_core_macros.svh
// Assertion macros for the HPACK string packer.
// Included by the top level; no other dependencies.
`ifndef HPACK_HUFFMAN_STRING_PACKER_CORE_MACROS_SVH
`define HPACK_HUFFMAN_STRING_PACKER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define HP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/hpack_pkg.sv
// Shared types, constants and the static Huffman code table.
// No dependencies.
`default_nettype none
package hpack_pkg;
  localparam int CodeW = 30;
  localparam int LenW  = 5;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;

  // Classified request between front and back
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;   // code length minus one
    logic             huff;
    logic             last;
  } hp_req_t;

  function automatic logic [34:0] hp_lookup(input logic [7:0] b);
    logic [29:0] c;
    logic [4:0]  l;
    begin
      c = '0; l = '0;
      unique case (b)
        8'd0:   begin c = 30'h1ff8; l = 5'd13; end
        8'd1:   begin c = 30'h7fffd8; l = 5'd23; end
        8'd2:   begin c = 30'hfffffe2; l = 5'd28; end
        8'd3:   begin c = 30'hfffffe3; l = 5'd28; end
        8'd4:   begin c = 30'hfffffe4; l = 5'd28; end
        8'd5:   begin c = 30'hfffffe5; l = 5'd28; end
        8'd6:   begin c = 30'hfffffe6; l = 5'd28; end
        8'd7:   begin c = 30'hfffffe7; l = 5'd28; end
        8'd8:   begin c = 30'hfffffe8; l = 5'd28; end
        8'd9:   begin c = 30'hffffea; l = 5'd24; end
        8'd10:  begin c = 30'h3ffffffc; l = 5'd30; end
        8'd11:  begin c = 30'hfffffe9; l = 5'd28; end
        8'd12:  begin c = 30'hfffffea; l = 5'd28; end
        8'd13:  begin c = 30'h3ffffffd; l = 5'd30; end
        8'd14:  begin c = 30'hfffffeb; l = 5'd28; end
        8'd15:  begin c = 30'hfffffec; l = 5'd28; end
        8'd16:  begin c = 30'hfffffed; l = 5'd28; end
        8'd17:  begin c = 30'hfffffee; l = 5'd28; end
        8'd18:  begin c = 30'hfffffef; l = 5'd28; end
        8'd19:  begin c = 30'hffffff0; l = 5'd28; end
        8'd20:  begin c = 30'hffffff1; l = 5'd28; end
        8'd21:  begin c = 30'hffffff2; l = 5'd28; end
        8'd22:  begin c = 30'h3ffffffe; l = 5'd30; end
        8'd23:  begin c = 30'hffffff3; l = 5'd28; end
        8'd24:  begin c = 30'hffffff4; l = 5'd28; end
        8'd25:  begin c = 30'hffffff5; l = 5'd28; end
        8'd26:  begin c = 30'hffffff6; l = 5'd28; end
        8'd27:  begin c = 30'hffffff7; l = 5'd28; end
        8'd28:  begin c = 30'hffffff8; l = 5'd28; end
        8'd29:  begin c = 30'hffffff9; l = 5'd28; end
        8'd30:  begin c = 30'hffffffa; l = 5'd28; end
        8'd31:  begin c = 30'hffffffb; l = 5'd28; end
        8'd32:  begin c = 30'h14; l = 5'd6; end
        8'd33:  begin c = 30'h3f8; l = 5'd10; end
        8'd34:  begin c = 30'h3f9; l = 5'd10; end
        8'd35:  begin c = 30'hffa; l = 5'd12; end
        8'd36:  begin c = 30'h1ff9; l = 5'd13; end
        8'd37:  begin c = 30'h15; l = 5'd6; end
        8'd38:  begin c = 30'hf8; l = 5'd8; end
        8'd39:  begin c = 30'h7fa; l = 5'd11; end
        8'd40:  begin c = 30'h3fa; l = 5'd10; end
        8'd41:  begin c = 30'h3fb; l = 5'd10; end
        8'd42:  begin c = 30'hf9; l = 5'd8; end
        8'd43:  begin c = 30'h7fb; l = 5'd11; end
        8'd44:  begin c = 30'hfa; l = 5'd8; end
        8'd45:  begin c = 30'h16; l = 5'd6; end
        8'd46:  begin c = 30'h17; l = 5'd6; end
        8'd47:  begin c = 30'h18; l = 5'd6; end
        8'd48:  begin c = 30'h0; l = 5'd5; end
        8'd49:  begin c = 30'h1; l = 5'd5; end
        8'd50:  begin c = 30'h2; l = 5'd5; end
        8'd51:  begin c = 30'h19; l = 5'd6; end
        8'd52:  begin c = 30'h1a; l = 5'd6; end
        8'd53:  begin c = 30'h1b; l = 5'd6; end
        8'd54:  begin c = 30'h1c; l = 5'd6; end
        8'd55:  begin c = 30'h1d; l = 5'd6; end
        8'd56:  begin c = 30'h1e; l = 5'd6; end
        8'd57:  begin c = 30'h1f; l = 5'd6; end
        8'd58:  begin c = 30'h5c; l = 5'd7; end
        8'd59:  begin c = 30'hfb; l = 5'd8; end
        8'd60:  begin c = 30'h7ffc; l = 5'd15; end
        8'd61:  begin c = 30'h20; l = 5'd6; end
        8'd62:  begin c = 30'hffb; l = 5'd12; end
        8'd63:  begin c = 30'h3fc; l = 5'd10; end
        8'd64:  begin c = 30'h1ffa; l = 5'd13; end
        8'd65:  begin c = 30'h21; l = 5'd6; end
        8'd66:  begin c = 30'h5d; l = 5'd7; end
        8'd67:  begin c = 30'h5e; l = 5'd7; end
        8'd68:  begin c = 30'h5f; l = 5'd7; end
        8'd69:  begin c = 30'h60; l = 5'd7; end
        8'd70:  begin c = 30'h61; l = 5'd7; end
        8'd71:  begin c = 30'h62; l = 5'd7; end
        8'd72:  begin c = 30'h63; l = 5'd7; end
        8'd73:  begin c = 30'h64; l = 5'd7; end
        8'd74:  begin c = 30'h65; l = 5'd7; end
        8'd75:  begin c = 30'h66; l = 5'd7; end
        8'd76:  begin c = 30'h67; l = 5'd7; end
        8'd77:  begin c = 30'h68; l = 5'd7; end
        8'd78:  begin c = 30'h69; l = 5'd7; end
        8'd79:  begin c = 30'h6a; l = 5'd7; end
        8'd80:  begin c = 30'h6b; l = 5'd7; end
        8'd81:  begin c = 30'h6c; l = 5'd7; end
        8'd82:  begin c = 30'h6d; l = 5'd7; end
        8'd83:  begin c = 30'h6e; l = 5'd7; end
        8'd84:  begin c = 30'h6f; l = 5'd7; end
        8'd85:  begin c = 30'h70; l = 5'd7; end
        8'd86:  begin c = 30'h71; l = 5'd7; end
        8'd87:  begin c = 30'h72; l = 5'd7; end
        8'd88:  begin c = 30'hfc; l = 5'd8; end
        8'd89:  begin c = 30'h73; l = 5'd7; end
        8'd90:  begin c = 30'hfd; l = 5'd8; end
        8'd91:  begin c = 30'h1ffb; l = 5'd13; end
        8'd92:  begin c = 30'h7fff0; l = 5'd19; end
        8'd93:  begin c = 30'h1ffc; l = 5'd13; end
        8'd94:  begin c = 30'h3ffc; l = 5'd14; end
        8'd95:  begin c = 30'h22; l = 5'd6; end
        8'd96:  begin c = 30'h7ffd; l = 5'd15; end
        8'd97:  begin c = 30'h3; l = 5'd5; end
        8'd98:  begin c = 30'h23; l = 5'd6; end
        8'd99:  begin c = 30'h4; l = 5'd5; end
        8'd100: begin c = 30'h24; l = 5'd6; end
        8'd101: begin c = 30'h5; l = 5'd5; end
        8'd102: begin c = 30'h25; l = 5'd6; end
        8'd103: begin c = 30'h26; l = 5'd6; end
        8'd104: begin c = 30'h27; l = 5'd6; end
        8'd105: begin c = 30'h6; l = 5'd5; end
        8'd106: begin c = 30'h74; l = 5'd7; end
        8'd107: begin c = 30'h75; l = 5'd7; end
        8'd108: begin c = 30'h28; l = 5'd6; end
        8'd109: begin c = 30'h29; l = 5'd6; end
        8'd110: begin c = 30'h2a; l = 5'd6; end
        8'd111: begin c = 30'h7; l = 5'd5; end
        8'd112: begin c = 30'h2b; l = 5'd6; end
        8'd113: begin c = 30'h76; l = 5'd7; end
        8'd114: begin c = 30'h2c; l = 5'd6; end
        8'd115: begin c = 30'h8; l = 5'd5; end
        8'd116: begin c = 30'h9; l = 5'd5; end
        8'd117: begin c = 30'h2d; l = 5'd6; end
        8'd118: begin c = 30'h77; l = 5'd7; end
        8'd119: begin c = 30'h78; l = 5'd7; end
        8'd120: begin c = 30'h79; l = 5'd7; end
        8'd121: begin c = 30'h7a; l = 5'd7; end
        8'd122: begin c = 30'h7b; l = 5'd7; end
        8'd123: begin c = 30'h7ffe; l = 5'd15; end
        8'd124: begin c = 30'h7fc; l = 5'd11; end
        8'd125: begin c = 30'h3ffd; l = 5'd14; end
        8'd126: begin c = 30'h1ffd; l = 5'd13; end
        8'd127: begin c = 30'hffffffc; l = 5'd28; end
        8'd128: begin c = 30'hfffe6; l = 5'd20; end
        8'd129: begin c = 30'h3fffd2; l = 5'd22; end
        8'd130: begin c = 30'hfffe7; l = 5'd20; end
        8'd131: begin c = 30'hfffe8; l = 5'd20; end
        8'd132: begin c = 30'h3fffd3; l = 5'd22; end
        8'd133: begin c = 30'h3fffd4; l = 5'd22; end
        8'd134: begin c = 30'h3fffd5; l = 5'd22; end
        8'd135: begin c = 30'h7fffd9; l = 5'd23; end
        8'd136: begin c = 30'h3fffd6; l = 5'd22; end
        8'd137: begin c = 30'h7fffda; l = 5'd23; end
        8'd138: begin c = 30'h7fffdb; l = 5'd23; end
        8'd139: begin c = 30'h7fffdc; l = 5'd23; end
        8'd140: begin c = 30'h7fffdd; l = 5'd23; end
        8'd141: begin c = 30'h7fffde; l = 5'd23; end
        8'd142: begin c = 30'hffffeb; l = 5'd24; end
        8'd143: begin c = 30'h7fffdf; l = 5'd23; end
        8'd144: begin c = 30'hffffec; l = 5'd24; end
        8'd145: begin c = 30'hffffed; l = 5'd24; end
        8'd146: begin c = 30'h3fffd7; l = 5'd22; end
        8'd147: begin c = 30'h7fffe0; l = 5'd23; end
        8'd148: begin c = 30'hffffee; l = 5'd24; end
        8'd149: begin c = 30'h7fffe1; l = 5'd23; end
        8'd150: begin c = 30'h7fffe2; l = 5'd23; end
        8'd151: begin c = 30'h7fffe3; l = 5'd23; end
        8'd152: begin c = 30'h7fffe4; l = 5'd23; end
        8'd153: begin c = 30'h1fffdc; l = 5'd21; end
        8'd154: begin c = 30'h3fffd8; l = 5'd22; end
        8'd155: begin c = 30'h7fffe5; l = 5'd23; end
        8'd156: begin c = 30'h3fffd9; l = 5'd22; end
        8'd157: begin c = 30'h7fffe6; l = 5'd23; end
        8'd158: begin c = 30'h7fffe7; l = 5'd23; end
        8'd159: begin c = 30'hffffef; l = 5'd24; end
        8'd160: begin c = 30'h3fffda; l = 5'd22; end
        8'd161: begin c = 30'h1fffdd; l = 5'd21; end
        8'd162: begin c = 30'hfffe9; l = 5'd20; end
        8'd163: begin c = 30'h3fffdb; l = 5'd22; end
        8'd164: begin c = 30'h3fffdc; l = 5'd22; end
        8'd165: begin c = 30'h7fffe8; l = 5'd23; end
        8'd166: begin c = 30'h7fffe9; l = 5'd23; end
        8'd167: begin c = 30'h1fffde; l = 5'd21; end
        8'd168: begin c = 30'h7fffea; l = 5'd23; end
        8'd169: begin c = 30'h3fffdd; l = 5'd22; end
        8'd170: begin c = 30'h3fffde; l = 5'd22; end
        8'd171: begin c = 30'hfffff0; l = 5'd24; end
        8'd172: begin c = 30'h1fffdf; l = 5'd21; end
        8'd173: begin c = 30'h3fffdf; l = 5'd22; end
        8'd174: begin c = 30'h7fffeb; l = 5'd23; end
        8'd175: begin c = 30'h7fffec; l = 5'd23; end
        8'd176: begin c = 30'h1fffe0; l = 5'd21; end
        8'd177: begin c = 30'h1fffe1; l = 5'd21; end
        8'd178: begin c = 30'h3fffe0; l = 5'd22; end
        8'd179: begin c = 30'h1fffe2; l = 5'd21; end
        8'd180: begin c = 30'h7fffed; l = 5'd23; end
        8'd181: begin c = 30'h3fffe1; l = 5'd22; end
        8'd182: begin c = 30'h7fffee; l = 5'd23; end
        8'd183: begin c = 30'h7fffef; l = 5'd23; end
        8'd184: begin c = 30'hfffea; l = 5'd20; end
        8'd185: begin c = 30'h3fffe2; l = 5'd22; end
        8'd186: begin c = 30'h3fffe3; l = 5'd22; end
        8'd187: begin c = 30'h3fffe4; l = 5'd22; end
        8'd188: begin c = 30'h7ffff0; l = 5'd23; end
        8'd189: begin c = 30'h3fffe5; l = 5'd22; end
        8'd190: begin c = 30'h3fffe6; l = 5'd22; end
        8'd191: begin c = 30'h7ffff1; l = 5'd23; end
        8'd192: begin c = 30'h3ffffe0; l = 5'd26; end
        8'd193: begin c = 30'h3ffffe1; l = 5'd26; end
        8'd194: begin c = 30'hfffeb; l = 5'd20; end
        8'd195: begin c = 30'h7fff1; l = 5'd19; end
        8'd196: begin c = 30'h3fffe7; l = 5'd22; end
        8'd197: begin c = 30'h7ffff2; l = 5'd23; end
        8'd198: begin c = 30'h3fffe8; l = 5'd22; end
        8'd199: begin c = 30'h1ffffec; l = 5'd25; end
        8'd200: begin c = 30'h3ffffe2; l = 5'd26; end
        8'd201: begin c = 30'h3ffffe3; l = 5'd26; end
        8'd202: begin c = 30'h3ffffe4; l = 5'd26; end
        8'd203: begin c = 30'h7ffffde; l = 5'd27; end
        8'd204: begin c = 30'h7ffffdf; l = 5'd27; end
        8'd205: begin c = 30'h3ffffe5; l = 5'd26; end
        8'd206: begin c = 30'hfffff1; l = 5'd24; end
        8'd207: begin c = 30'h1ffffed; l = 5'd25; end
        8'd208: begin c = 30'h7fff2; l = 5'd19; end
        8'd209: begin c = 30'h1fffe3; l = 5'd21; end
        8'd210: begin c = 30'h3ffffe6; l = 5'd26; end
        8'd211: begin c = 30'h7ffffe0; l = 5'd27; end
        8'd212: begin c = 30'h7ffffe1; l = 5'd27; end
        8'd213: begin c = 30'h3ffffe7; l = 5'd26; end
        8'd214: begin c = 30'h7ffffe2; l = 5'd27; end
        8'd215: begin c = 30'hfffff2; l = 5'd24; end
        8'd216: begin c = 30'h1fffe4; l = 5'd21; end
        8'd217: begin c = 30'h1fffe5; l = 5'd21; end
        8'd218: begin c = 30'h3ffffe8; l = 5'd26; end
        8'd219: begin c = 30'h3ffffe9; l = 5'd26; end
        8'd220: begin c = 30'hffffffd; l = 5'd28; end
        8'd221: begin c = 30'h7ffffe3; l = 5'd27; end
        8'd222: begin c = 30'h7ffffe4; l = 5'd27; end
        8'd223: begin c = 30'h7ffffe5; l = 5'd27; end
        8'd224: begin c = 30'hfffec; l = 5'd20; end
        8'd225: begin c = 30'hfffff3; l = 5'd24; end
        8'd226: begin c = 30'hfffed; l = 5'd20; end
        8'd227: begin c = 30'h1fffe6; l = 5'd21; end
        8'd228: begin c = 30'h3fffe9; l = 5'd22; end
        8'd229: begin c = 30'h1fffe7; l = 5'd21; end
        8'd230: begin c = 30'h1fffe8; l = 5'd21; end
        8'd231: begin c = 30'h7ffff3; l = 5'd23; end
        8'd232: begin c = 30'h3fffea; l = 5'd22; end
        8'd233: begin c = 30'h3fffeb; l = 5'd22; end
        8'd234: begin c = 30'h1ffffee; l = 5'd25; end
        8'd235: begin c = 30'h1ffffef; l = 5'd25; end
        8'd236: begin c = 30'hfffff4; l = 5'd24; end
        8'd237: begin c = 30'hfffff5; l = 5'd24; end
        8'd238: begin c = 30'h3ffffea; l = 5'd26; end
        8'd239: begin c = 30'h7ffff4; l = 5'd23; end
        8'd240: begin c = 30'h3ffffeb; l = 5'd26; end
        8'd241: begin c = 30'h7ffffe6; l = 5'd27; end
        8'd242: begin c = 30'h3ffffec; l = 5'd26; end
        8'd243: begin c = 30'h3ffffed; l = 5'd26; end
        8'd244: begin c = 30'h7ffffe7; l = 5'd27; end
        8'd245: begin c = 30'h7ffffe8; l = 5'd27; end
        8'd246: begin c = 30'h7ffffe9; l = 5'd27; end
        8'd247: begin c = 30'h7ffffea; l = 5'd27; end
        8'd248: begin c = 30'h7ffffeb; l = 5'd27; end
        8'd249: begin c = 30'hffffffe; l = 5'd28; end
        8'd250: begin c = 30'h7ffffec; l = 5'd27; end
        8'd251: begin c = 30'h7ffffed; l = 5'd27; end
        8'd252: begin c = 30'h7ffffee; l = 5'd27; end
        8'd253: begin c = 30'h7ffffef; l = 5'd27; end
        8'd254: begin c = 30'h7fffff0; l = 5'd27; end
        8'd255: begin c = 30'h3ffffee; l = 5'd26; end
        default: begin c = '0; l = 5'd1; end
      endcase
      // store length minus one so 30 fits five bits with room
      hp_lookup = {c, 5'(l - 5'd1)};
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/hpack_front.sv
// Front end: looks up the Huffman code of each accepted byte and queues it.
// Depends on hpack_pkg.
`default_nettype none
module hpack_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_huff,
  input  wire logic            in_last,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output hpack_pkg::hp_req_t   q_head
);
  import hpack_pkg::*;

  hp_req_t                 mem [QDepth];
  logic [QPtrW-1:0]        wr_ptr;
  logic [QPtrW-1:0]        rd_ptr;
  logic [QPtrW:0]          count;
  logic [CodeW+LenW-1:0]   look;
  hp_req_t                 req;
  logic                    push;

  // Classify the incoming byte
  always_comb begin
    look = hp_lookup(in_byte);
    req.huff = in_huff;
    req.last = in_last;
    if (in_huff) begin
      req.code = look[CodeW+LenW-1:LenW];
      req.len  = look[LenW-1:0];
    end else begin
      req.code = {{(CodeW-8){1'b0}}, in_byte};
      req.len  = LenW'(7);
    end
  end

  assign in_ready = (count != (QPtrW+1)'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= req;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop && q_valid) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop && q_valid);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hpack_back.sv
// Back end: packs queued codes into bytes, pads at string end, drives output.
// Depends on hpack_pkg.
`default_nettype none
module hpack_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire hpack_pkg::hp_req_t q_head,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import hpack_pkg::*;

  // bits pending: up to 7 held plus 30 of code
  localparam int AccW = 37;

  logic [AccW-1:0] acc;
  logic [5:0]      cnt;
  logic            fin;
  logic            ovalid;
  logic [7:0]      obyte;
  logic            olast;
  logic            can_emit;
  logic [AccW-1:0] acc_load;
  logic [5:0]      cnt_load;
  logic [7:0]      top_byte;
  logic [7:0]      pad_byte;
  logic [5:0]      sh;
  logic [5:0]      len_full;

  assign out_valid = ovalid;
  assign out_byte  = obyte;
  assign out_last  = olast;
  assign can_emit  = !ovalid || out_ready;

  assign len_full = 6'(q_head.len) + 6'd1;
  assign sh       = (cnt >= 6'd8) ? 6'(cnt - 6'd8) : 6'd0;
  assign top_byte = 8'(acc >> sh);
  assign pad_byte = 8'((acc << (6'd8 - cnt)) | ((AccW'(1) << (6'd8 - cnt)) - 1'b1));

  // Load the next request when fewer than eight bits remain and no finish pending
  always_comb begin
    q_pop    = 1'b0;
    acc_load = acc;
    cnt_load = cnt;
    if (!fin && q_valid && cnt < 6'd8 && can_emit) begin
      if (q_head.huff) begin
        q_pop    = 1'b1;
        acc_load = (acc << len_full) | AccW'(q_head.code);
        cnt_load = cnt + len_full;
      end else if (cnt == 6'd0) begin
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      fin    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (can_emit) begin
        if (cnt >= 6'd8) begin
          // drop one full byte; flag it last if nothing remains and string ends
          obyte  <= top_byte;
          olast  <= fin && (cnt == 6'd8);
          ovalid <= 1'b1;
          cnt    <= cnt - 6'd8;
          if (cnt == 6'd8) fin <= 1'b0;
        end else if (fin && cnt != 6'd0) begin
          // pad tail of string with ones
          obyte  <= pad_byte;
          olast  <= 1'b1;
          ovalid <= 1'b1;
          cnt    <= '0;
          fin    <= 1'b0;
        end else if (q_valid && !q_head.huff && cnt != 6'd0) begin
          // mode switch: pad held bits, not last
          obyte  <= pad_byte;
          olast  <= 1'b0;
          ovalid <= 1'b1;
          cnt    <= '0;
        end else if (q_pop && !q_head.huff) begin
          obyte  <= q_head.code[7:0];
          olast  <= q_head.last;
          ovalid <= 1'b1;
        end else if (q_pop) begin
          acc    <= acc_load;
          cnt    <= cnt_load;
          fin    <= q_head.last;
          ovalid <= 1'b0;
        end else begin
          ovalid <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hpack_huffman_string_packer_core.sv
// HPACK string packer top level: joins the front end queue and back end packer.
// Depends on hpack_pkg, hpack_front, hpack_back and the macros header.
//
// Usage: input bytes arrive on s_axis; tdata carries data_byte, tuser carries
// use_huffman, tlast marks the final byte of a string (string_end). Packed
// bytes leave on m_axis with tdata = out_byte and tlast = out_last.
// The front end looks up the 5 to 30 bit code and writes a four-deep queue,
// so input is taken every cycle while the queue has room.
// The back end shifts codes into a 37-bit accumulator and emits at most one
// byte per cycle while the receiver takes bytes; a code is loaded, then each
// completed byte is emitted, and at string end a padded byte follows; a raw
// item is passed straight out, after a padded byte when bits are held; a new
// code is loaded only once fewer than eight bits remain.
// A raw byte passes through the queue and the output register; the first byte
// of a code of eight bits or more passes the queue, accumulator and output register.
// Reset clears the queue, the held bits and the output register.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready falls until bytes are taken again.
`default_nettype none
`include "hpack_huffman_string_packer_core_macros.svh"
module hpack_huffman_string_packer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tuser,   // [0] use_huffman
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);
  import hpack_pkg::*;

  logic    q_valid;
  logic    q_pop;
  hp_req_t q_head;

  hpack_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_huff  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  hpack_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  `HP_ASSERT_IMPL(a_pop_valid, clk, rst, q_pop, q_valid, "pop from empty queue")
  `HP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
endmodule
`default_nettype wire

FILE: sim/hpack_huffman_string_packer_core_chk.sv
// Checker for the HPACK string packer: watches both stream channels,
// predicts the packed bytes and compares them. Depends on no package.
module hpack_huffman_string_packer_core_chk (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tlast,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic [29:0]  code_tab [256];
  logic [4:0]   len_tab [256];
  logic [6:0]   held_bits;
  logic [2:0]   held_count;
  packed_byte_t byte_q [$];

  // Static Huffman code: codes and lengths, RFC 7541 Appendix B
  initial begin
    logic [29:0] c [256];
    int          l [256];
    c = '{
      'h1ff8,'h7fffd8,'hfffffe2,'hfffffe3,'hfffffe4,'hfffffe5,'hfffffe6,'hfffffe7,
      'hfffffe8,'hffffea,'h3ffffffc,'hfffffe9,'hfffffea,'h3ffffffd,'hfffffeb,'hfffffec,
      'hfffffed,'hfffffee,'hfffffef,'hffffff0,'hffffff1,'hffffff2,'h3ffffffe,'hffffff3,
      'hffffff4,'hffffff5,'hffffff6,'hffffff7,'hffffff8,'hffffff9,'hffffffa,'hffffffb,
      'h14,'h3f8,'h3f9,'hffa,'h1ff9,'h15,'hf8,'h7fa,
      'h3fa,'h3fb,'hf9,'h7fb,'hfa,'h16,'h17,'h18,
      'h0,'h1,'h2,'h19,'h1a,'h1b,'h1c,'h1d,
      'h1e,'h1f,'h5c,'hfb,'h7ffc,'h20,'hffb,'h3fc,
      'h1ffa,'h21,'h5d,'h5e,'h5f,'h60,'h61,'h62,
      'h63,'h64,'h65,'h66,'h67,'h68,'h69,'h6a,
      'h6b,'h6c,'h6d,'h6e,'h6f,'h70,'h71,'h72,
      'hfc,'h73,'hfd,'h1ffb,'h7fff0,'h1ffc,'h3ffc,'h22,
      'h7ffd,'h3,'h23,'h4,'h24,'h5,'h25,'h26,
      'h27,'h6,'h74,'h75,'h28,'h29,'h2a,'h7,
      'h2b,'h76,'h2c,'h8,'h9,'h2d,'h77,'h78,
      'h79,'h7a,'h7b,'h7ffe,'h7fc,'h3ffd,'h1ffd,'hffffffc,
      'hfffe6,'h3fffd2,'hfffe7,'hfffe8,'h3fffd3,'h3fffd4,'h3fffd5,'h7fffd9,
      'h3fffd6,'h7fffda,'h7fffdb,'h7fffdc,'h7fffdd,'h7fffde,'hffffeb,'h7fffdf,
      'hffffec,'hffffed,'h3fffd7,'h7fffe0,'hffffee,'h7fffe1,'h7fffe2,'h7fffe3,
      'h7fffe4,'h1fffdc,'h3fffd8,'h7fffe5,'h3fffd9,'h7fffe6,'h7fffe7,'hffffef,
      'h3fffda,'h1fffdd,'hfffe9,'h3fffdb,'h3fffdc,'h7fffe8,'h7fffe9,'h1fffde,
      'h7fffea,'h3fffdd,'h3fffde,'hfffff0,'h1fffdf,'h3fffdf,'h7fffeb,'h7fffec,
      'h1fffe0,'h1fffe1,'h3fffe0,'h1fffe2,'h7fffed,'h3fffe1,'h7fffee,'h7fffef,
      'hfffea,'h3fffe2,'h3fffe3,'h3fffe4,'h7ffff0,'h3fffe5,'h3fffe6,'h7ffff1,
      'h3ffffe0,'h3ffffe1,'hfffeb,'h7fff1,'h3fffe7,'h7ffff2,'h3fffe8,'h1ffffec,
      'h3ffffe2,'h3ffffe3,'h3ffffe4,'h7ffffde,'h7ffffdf,'h3ffffe5,'hfffff1,'h1ffffed,
      'h7fff2,'h1fffe3,'h3ffffe6,'h7ffffe0,'h7ffffe1,'h3ffffe7,'h7ffffe2,'hfffff2,
      'h1fffe4,'h1fffe5,'h3ffffe8,'h3ffffe9,'hffffffd,'h7ffffe3,'h7ffffe4,'h7ffffe5,
      'hfffec,'hfffff3,'hfffed,'h1fffe6,'h3fffe9,'h1fffe7,'h1fffe8,'h7ffff3,
      'h3fffea,'h3fffeb,'h1ffffee,'h1ffffef,'hfffff4,'hfffff5,'h3ffffea,'h7ffff4,
      'h3ffffeb,'h7ffffe6,'h3ffffec,'h3ffffed,'h7ffffe7,'h7ffffe8,'h7ffffe9,'h7ffffea,
      'h7ffffeb,'hffffffe,'h7ffffec,'h7ffffed,'h7ffffee,'h7ffffef,'h7fffff0,'h3ffffee};
    l = '{
      13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
      28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
      6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
      5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
      13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
      7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
      15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
      6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
      20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
      24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
      22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
      21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
      26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
      19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
      20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
      26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
    for (int i = 0; i < 256; i++) begin
      code_tab[i] = c[i];
      len_tab[i]  = 5'(l[i]);
    end
  end

  // Pad the held bits with ones up to a byte
  function automatic logic [7:0] pad_held(logic [6:0] bits, logic [2:0] cnt);
    logic [15:0] v;
    int          fill;
    fill = 8 - cnt;
    v = (16'(bits) << fill) | ((16'd1 << fill) - 16'd1);
    return v[7:0];
  endfunction

  // Queue one expected byte at the tail
  task automatic queue_byte(logic [7:0] d, logic l);
    packed_byte_t item;
    item.data = d;
    item.last = l;
    byte_q.insert(byte_q.size(), item);
  endtask

  // Append the packed bytes that one request produces
  task automatic pack_request(logic [7:0] b, logic huff, logic fin);
    logic [36:0] acc;
    int          total;
    int          n;
    n = 0;
    if (!huff) begin
      if (held_count != 0) queue_byte(pad_held(held_bits, held_count), 1'b0);
      queue_byte(b, fin);
      held_bits = '0;
      held_count = '0;
      return;
    end
    acc = (37'(held_bits) << len_tab[b]) | 37'(code_tab[b]);
    total = held_count + len_tab[b];
    while (total >= 8) begin
      total -= 8;
      queue_byte(8'(acc >> total), 1'b0);
      n++;
    end
    held_bits = 7'(acc & ((37'd1 << total) - 37'd1));
    held_count = 3'(total);
    if (fin) begin
      if (held_count != 0) queue_byte(pad_held(held_bits, held_count), 1'b1);
      else if (n > 0) byte_q[$].last = 1'b1;
      held_bits = '0;
      held_count = '0;
    end
  endtask

  // Predict on accepted requests, compare accepted output bytes
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      held_bits = '0;
      held_count = '0;
      byte_q.delete();
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pack_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (byte_q.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = byte_q.pop_front();
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
            $display("%0t: expected byte %h last %b, got %h last %b", $time,
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
    pending_count = byte_q.size();
  end
endmodule

FILE: sim/hpack_huffman_string_packer_core_tb.sv
// Testbench top for the HPACK string packer: clock, reset, request stimulus
// and verdict. Depends on the packer RTL and hpack_huffman_string_packer_core_chk.
module hpack_huffman_string_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] data_byte
  logic       s_axis_tuser = 1'b0; // [0] use_huffman
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic       m_axis_tlast;
  int         fail_count;
  int         pending_count;
  int         cycle_count = 0;
  bit         hold_off = 1'b0;

  always #2 clk = ~clk;

  hpack_huffman_string_packer_core i_dut (.*);
  hpack_huffman_string_packer_core_chk i_chk (.*);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off
  initial begin
    int n;
    repeat (5) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      n = cycle_count % 300;
      if (n < 80) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Offer one request and hold it until taken
  task automatic send_request(logic [7:0] b, logic huff, logic fin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= huff;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    int len;
    int sent;
    logic huff;
    logic [7:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, boundary end, mode switch, raw strings
    send_request(8'd0, 1'b1, 1'b1);      // 13 bits
    send_request(8'd255, 1'b1, 1'b1);    // 26 bits
    send_request(8'd10, 1'b1, 1'b0);     // 30 bits
    send_request(8'd13, 1'b1, 1'b0);
    send_request(8'd22, 1'b1, 1'b1);
    send_request(8'd38, 1'b1, 1'b1);     // 8 bits exact boundary
    send_request(8'd48, 1'b1, 1'b0);     // 5 bits
    send_request(8'd97, 1'b1, 1'b0);
    send_request(8'd50, 1'b1, 1'b0);
    send_request(8'd101, 1'b1, 1'b0);
    send_request(8'd49, 1'b1, 1'b0);
    send_request(8'd99, 1'b1, 1'b0);
    send_request(8'd111, 1'b1, 1'b0);
    send_request(8'd115, 1'b1, 1'b1);    // 40 bits exact boundary
    send_request(8'd97, 1'b1, 1'b0);     // held bits, then raw
    send_request(8'd170, 1'b0, 1'b0);
    send_request(8'd85, 1'b0, 1'b1);
    send_request(8'd0, 1'b0, 1'b1);
    send_request(8'd255, 1'b0, 1'b1);
    send_request(8'd48, 1'b1, 1'b0);     // no output yet, then end
    send_request(8'd48, 1'b1, 1'b1);

    // Long receiver hold-off while requests keep coming
    hold_off = 1'b1;

    // Random strings, mostly Huffman, some mode switches inside
    sent = 0;
    while (sent < 140) begin
      len = $urandom_range(1, 8);
      huff = $urandom_range(0, 4) != 0;
      for (int i = 0; i < len; i++) begin
        b = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(32, 126));
        if ($urandom_range(0, 15) == 0) huff = ~huff;
        send_request(b, huff, i == len - 1);
        sent++;
        idle_gap();
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    // Drain, then a short settling wait
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
